@@ design/irut_pkg.sv @@
// Shared types, constants and codes for the infrared-carrier serial transmitter.
package irut_pkg;

   localparam int DATA_BITS_DEF = 8;
   localparam int BYTE_W        = 8;
   localparam int CNT_W         = 10;
   localparam int HPB_W         = 8;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 10;

   localparam logic [HPB_W-1:0] HPB_RST   = HPB_W'(60);
   localparam logic [CNT_W-1:0] STOP1_RST = CNT_W'(120);
   localparam logic [CNT_W-1:0] STOP2_RST = CNT_W'(60);

   typedef enum logic {
      FUNC_TICK = 1'b0,
      FUNC_BYTE = 1'b1
   } func_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_HALF_PERIODS = 2'd0,
      CSR_FIRST_STOP   = 2'd1,
      CSR_SECOND_STOP  = 2'd2,
      CSR_IDLE_HIGH    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [HPB_W-1:0] half_periods_per_bit;
      logic [CNT_W-1:0] first_stop_length;
      logic [CNT_W-1:0] second_stop_length;
      logic             idle_high;
   } cfg_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic refused;
      logic frame_done;
   } result_type;

   typedef struct packed {
      logic busy;
      logic at_frame_start;
   } status_type;

endpackage

@@ design/ir_carrier_uart_transmitter.sv @@
// Top level of the infrared-carrier serial transmitter with its stream ports.
//
// Sends bytes as asynchronous serial frames (start bit, DATA_BITS data bits
// least significant first, two stop bits) keyed onto an infrared carrier.
// Every request transaction is either a carrier half-period tick (req_tuser
// low) or a byte offer (req_tuser high, byte in req_tdata). Each request gives
// exactly one response transaction that reports the pin level, the busy flag,
// a refused flag for a byte offered while a frame is running, and rsp_tlast on
// the tick that ends the second stop bit. During the start bit and zero data
// bits the pin toggles on each tick; otherwise it sits at the idle level set
// by the idle_high register. Each request is handled by a single counter
// compare and shift between the sequencer registers and the result register,
// so one transaction per cycle is sustained while the result register is
// empty or being drained, which is also when a new request is taken.
// Configuration registers (index 0 half periods per bit, 1 first stop length,
// 2 second stop length, 3 idle high) are written through csr_we and should be
// changed only while no transaction is outstanding.
module ir_carrier_uart_transmitter #(
   parameter int DATA_BITS = irut_pkg::DATA_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [irut_pkg::BYTE_W-1:0]       req_tdata,  // [7:0] data_byte
   input  logic                              req_tuser,  // [0] func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // [0] pin_level, [1] busy_res,
                                                         // [2] refused, [7:3] zero
   output logic                              rsp_tlast,  // frame_done
   input  logic                              csr_we,
   input  logic [irut_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [irut_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   irut_pkg::cfg_type    cfg;
   irut_pkg::result_type step_res;
   irut_pkg::result_type out_res;
   irut_pkg::status_type status;
   logic                 accept;
   logic                 can_load;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   irut_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irut_frame_ctl #(
      .DATA_BITS (DATA_BITS)
   ) u_frame_ctl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_tuser),
      .data_byte (req_tdata),
      .cfg       (cfg),
      .res       (step_res),
      .status    (status)
   );

   irut_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .res_in    (step_res),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .res_out   (out_res),
      .can_load  (can_load)
   );

   assign rsp_tdata = {5'b0, out_res.refused, out_res.busy_res, out_res.pin_level};
   assign rsp_tlast = out_res.frame_done;

   // A finished frame always leaves the transmitter idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[1])
      else $error("frame end reported while still busy");

   // A byte is refused only while a frame is running.
   a_refused_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1] && !rsp_tlast)
      else $error("refused flag without a running frame");

   // When idle, the sequencer rests at the start of a frame.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !status.busy |-> status.at_frame_start)
      else $error("sequencer counters not cleared while idle");

   // A busy result must come from a busy sequencer after the transaction.
   a_busy_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> status.busy == rsp_tdata[1])
      else $error("reported busy flag disagrees with sequencer state");

endmodule

@@ design/irut_csr.sv @@
// Configuration register bank of the infrared-carrier serial transmitter.
module irut_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [irut_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [irut_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output irut_pkg::cfg_type                cfg
);

   irut_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (irut_pkg::csr_index_type'(csr_addr))
            irut_pkg::CSR_HALF_PERIODS:
               cfg_in.half_periods_per_bit = csr_wdata[irut_pkg::HPB_W-1:0];
            irut_pkg::CSR_FIRST_STOP:
               cfg_in.first_stop_length = csr_wdata[irut_pkg::CNT_W-1:0];
            irut_pkg::CSR_SECOND_STOP:
               cfg_in.second_stop_length = csr_wdata[irut_pkg::CNT_W-1:0];
            irut_pkg::CSR_IDLE_HIGH:
               cfg_in.idle_high = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_periods_per_bit <= irut_pkg::HPB_RST;
         cfg_ff.first_stop_length    <= irut_pkg::STOP1_RST;
         cfg_ff.second_stop_length   <= irut_pkg::STOP2_RST;
         cfg_ff.idle_high            <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/irut_frame_ctl.sv @@
// Frame sequencer: segment and tick counters, data shifter and pin register.
module irut_frame_ctl #(
   parameter int DATA_BITS = irut_pkg::DATA_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          func,
   input  logic [irut_pkg::BYTE_W-1:0]   data_byte,
   input  irut_pkg::cfg_type             cfg,
   output irut_pkg::result_type          res,
   output irut_pkg::status_type          status
);

   localparam int SEG_W = $clog2(DATA_BITS + 3);
   localparam logic [SEG_W-1:0] SEG_LAST_DATA = SEG_W'(DATA_BITS);
   localparam logic [SEG_W-1:0] SEG_STOP1     = SEG_W'(DATA_BITS + 1);
   localparam logic [SEG_W-1:0] SEG_STOP2     = SEG_W'(DATA_BITS + 2);

   logic                          busy_ff, busy_in;
   logic [SEG_W-1:0]              seg_ff, seg_in;
   logic [irut_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [irut_pkg::BYTE_W-1:0]   shift_ff, shift_in;
   logic                          pin_ff, pin_in;

   logic                          is_data;
   logic                          modulate;
   logic [irut_pkg::CNT_W-1:0]    seg_len;
   logic [irut_pkg::CNT_W-1:0]    cnt_inc;
   logic                          seg_end;
   logic                          refused;
   logic                          done;

   assign is_data  = (seg_ff != '0) && (seg_ff <= SEG_LAST_DATA);
   assign modulate = (seg_ff == '0) || (is_data && !shift_ff[0]);
   assign cnt_inc  = cnt_ff + irut_pkg::CNT_W'(1);

   always_comb begin
      if (seg_ff <= SEG_LAST_DATA) begin
         seg_len = irut_pkg::CNT_W'(cfg.half_periods_per_bit);
      end else if (seg_ff == SEG_STOP1) begin
         seg_len = cfg.first_stop_length;
      end else begin
         seg_len = cfg.second_stop_length;
      end
   end

   // A zero length also ends here, since any count reaches it.
   assign seg_end = (cnt_inc >= seg_len);

   always_comb begin
      busy_in  = busy_ff;
      seg_in   = seg_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      pin_in   = pin_ff;
      refused  = 1'b0;
      done     = 1'b0;
      if (func == irut_pkg::FUNC_BYTE) begin
         if (busy_ff) begin
            refused = 1'b1;
         end else begin
            busy_in  = 1'b1;
            seg_in   = '0;
            cnt_in   = '0;
            shift_in = data_byte;
         end
      end else if (!busy_ff) begin
         pin_in = cfg.idle_high;
      end else begin
         pin_in = modulate ? !pin_ff : cfg.idle_high;
         cnt_in = cnt_inc;
         if (seg_end) begin
            cnt_in = '0;
            if (is_data) begin
               shift_in = shift_ff >> 1;
            end
            if (seg_ff >= SEG_STOP2) begin
               busy_in = 1'b0;
               seg_in  = '0;
               done    = 1'b1;
            end else begin
               seg_in = seg_ff + SEG_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         seg_ff   <= '0;
         cnt_ff   <= '0;
         shift_ff <= '0;
         pin_ff   <= 1'b0;
      end else if (accept) begin
         busy_ff  <= busy_in;
         seg_ff   <= seg_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         pin_ff   <= pin_in;
      end
   end

   assign res.pin_level  = pin_in;
   assign res.busy_res   = busy_in;
   assign res.refused    = refused;
   assign res.frame_done = done;

   assign status.busy           = busy_ff;
   assign status.at_frame_start = (seg_ff == '0) && (cnt_ff == '0);

endmodule

@@ design/irut_out_reg.sv @@
// Result register between the sequencer and the result stream.
module irut_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  irut_pkg::result_type  res_in,
   input  logic                  out_ready,
   output logic                  out_valid,
   output irut_pkg::result_type  res_out,
   output logic                  can_load
);

   logic                 valid_ff, valid_in;
   irut_pkg::result_type res_ff;

   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign res_out   = res_ff;

endmodule
